// ===== hdl/block_bitmap_allocator_unit_defines.svh =====
// ----------------------------------------------------------------------------
// block bitmap allocator assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef BLOCK_BITMAP_ALLOCATOR_UNIT_DEFINES_SVH
`define BLOCK_BITMAP_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define BBA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BBA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/bba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_pkg
// field widths, map capacity, request kinds and status codes of the block
// bitmap allocator
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int BLOCK_W    = 12;
    localparam int SIZE_W     = 13;
    localparam int STATUS_W   = 2;
    localparam int TDATA_W    = 16;
    // map capacity in blocks, tied to the block number width
    localparam int MAX_BLOCKS = 4096;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 2'd0,
        ST_FULL        = 2'd1,
        ST_DOUBLE_FREE = 2'd2,
        ST_RANGE       = 2'd3
    } status_t;

    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } req_t;

endpackage

// ===== hdl/block_bitmap_allocator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_bitmap_allocator_unit
// one-bit-per-block usage map with allocate and free requests
// ----------------------------------------------------------------------------
// usage:
//   requests come in on the s_ channel (s_tuser = request kind, s_tdata =
//   block number), one result per request leaves on the m_ channel
//   (m_tdata = granted block and status). the cfg channel writes the file
//   system size in blocks; write it only while no request is in flight.
// request sequence:
//   one request at a time. a free reads its map word, checks it in SCAN and
//   then waits in FIN; an out-of-range free or an allocate at size zero goes
//   straight to FIN. an allocate streams the map through the memory read port
//   one word per cycle, at most the words that the size covers, until it
//   finds a clear bit or reaches the last word. the map memory has a single
//   read port with a registered output.
// reset:
//   every map word is marked unwritten by a per-word valid flag, so the map
//   reads as all blocks free straight after reset, with no clearing pass.
//   the size register resets to 4096.
// stalls:
//   the result sits in an output register; while the receiver stalls, a
//   finished request waits before its map write-back and no new request is
//   taken. a new request may be accepted while the previous result waits.
// ----------------------------------------------------------------------------
`include "block_bitmap_allocator_unit_defines.svh"

module block_bitmap_allocator_unit #(
    parameter int MAP_WORD_BITS = 32     // power of two
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // request channel
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [bba_pkg::TDATA_W-1:0] s_tdata,   // [11:0] block_number, [15:12] zero
    input  logic                        s_tuser,   // [0] req_type
    // result channel
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [bba_pkg::TDATA_W-1:0] m_tdata,   // [11:0] alloc_block, [13:12] status,
                                                   // [15:14] zero
    // size register write channel
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [bba_pkg::SIZE_W-1:0]  cfg_data   // fs_size_blocks
);

    localparam int W      = MAP_WORD_BITS;
    localparam int SH     = $clog2(MAP_WORD_BITS);
    localparam int WORDS  = (bba_pkg::MAX_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int LW_MAX = $clog2(bba_pkg::MAX_BLOCKS + 1);
    localparam int LW     = (bba_pkg::SIZE_W > LW_MAX) ? bba_pkg::SIZE_W : LW_MAX;
    localparam int BW     = bba_pkg::BLOCK_W;

    typedef enum logic [1:0] {
        IDLE,
        SCAN,
        FIN
    } state_t;

    // control and request context
    state_t                   state_reg;
    bba_pkg::req_t            req_reg;
    logic [SH-1:0]            blk_off_reg;
    logic [LW-1:0]            lim_reg;
    logic [AW-1:0]            last_word_reg;
    logic [SH-1:0]            tail_rem_reg;
    logic [AW-1:0]            chk_addr_reg;
    logic [AW-1:0]            issue_addr_reg;
    logic [bba_pkg::SIZE_W-1:0] fs_size_reg;

    // pending write-back and result
    logic                     wr_en_reg;
    logic [AW-1:0]            wr_addr_reg;
    logic [W-1:0]             wr_data_reg;
    logic [BW-1:0]            grant_reg;
    bba_pkg::status_t         status_reg;
    logic                     m_tvalid_reg;
    logic [BW-1:0]            m_block_reg;
    bba_pkg::status_t         m_status_reg;

    // map memory, valid flags and read port
    logic [W-1:0]             map_mem [WORDS];
    logic [WORDS-1:0]         map_vld_reg;
    logic [W-1:0]             rd_data_reg;
    logic                     rd_vld_reg;
    logic [AW-1:0]            rd_addr;

    // request decode
    bba_pkg::req_t            in_req;
    logic [BW-1:0]            in_blk;
    logic [LW-1:0]            in_blk_ext;
    logic [LW-1:0]            lim;
    logic [AW-1:0]            in_word;

    // word check
    logic [W-1:0]             word_cur;
    logic                     last_hit;
    logic [W-1:0]             pad_mask;
    logic [W-1:0]             eff_word;
    logic                     found;
    logic [SH-1:0]            found_idx;
    logic [LW-1:0]            grant_ext;
    logic                     out_load;
    logic                     mem_we;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {2'b00, m_status_reg, m_block_reg};

    assign in_req     = bba_pkg::req_t'(s_tuser);
    assign in_blk     = s_tdata[BW-1:0];
    assign in_blk_ext = LW'(in_blk);
    assign in_word    = AW'(in_blk_ext >> SH);

    // effective size, capped at the map capacity
    assign lim = (LW'(fs_size_reg) > LW'(bba_pkg::MAX_BLOCKS)) ? LW'(bba_pkg::MAX_BLOCKS)
                                                               : LW'(fs_size_reg);

    // read address: first word at acceptance, then the scan pointer
    always_comb
    begin
        if (state_reg == IDLE)
        begin
            rd_addr = (in_req == bba_pkg::REQ_FREE) ? in_word : '0;
        end
        else
        begin
            rd_addr = issue_addr_reg;
        end
    end

    // unwritten words read as free
    assign word_cur = rd_vld_reg ? rd_data_reg : '0;
    assign last_hit = (chk_addr_reg == last_word_reg);
    // bits at or above the size in the last word count as used
    assign pad_mask = (tail_rem_reg == '0) ? '0 : ({W{1'b1}} << tail_rem_reg);
    assign eff_word = word_cur | (last_hit ? pad_mask : '0);

    // lowest clear bit
    always_comb
    begin
        found     = 1'b0;
        found_idx = '0;
        for (int i = W - 1; i >= 0; i--)
        begin
            if (!eff_word[i])
            begin
                found     = 1'b1;
                found_idx = SH'(i);
            end
        end
    end

    assign grant_ext = (LW'(chk_addr_reg) << SH) | LW'(found_idx);

    assign out_load = (state_reg == FIN) && (!m_tvalid_reg || m_tready);
    assign mem_we   = out_load && wr_en_reg;

    // map memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            map_mem[wr_addr_reg] <= wr_data_reg;
        end
        rd_data_reg <= map_mem[rd_addr];
        rd_vld_reg  <= map_vld_reg[rd_addr];
    end

    // per-word written flags, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_vld_reg <= '0;
        end
        else if (mem_we)
        begin
            map_vld_reg[wr_addr_reg] <= 1'b1;
        end
    end

    // size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fs_size_reg <= bba_pkg::SIZE_W'(4096);
        end
        else if (cfg_valid && cfg_ready)
        begin
            fs_size_reg <= cfg_data;
        end
    end

    // request sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= IDLE;
            m_tvalid_reg   <= 1'b0;
            wr_en_reg      <= 1'b0;
            req_reg        <= bba_pkg::REQ_ALLOC;
            blk_off_reg    <= '0;
            lim_reg        <= '0;
            last_word_reg  <= '0;
            tail_rem_reg   <= '0;
            chk_addr_reg   <= '0;
            issue_addr_reg <= '0;
            wr_addr_reg    <= '0;
            wr_data_reg    <= '0;
            grant_reg      <= '0;
            status_reg     <= bba_pkg::ST_OK;
            m_block_reg    <= '0;
            m_status_reg   <= bba_pkg::ST_OK;
        end
        else
        begin
            // output register empties unless a new result loads at the same edge
            if (m_tvalid_reg && m_tready && !out_load)
            begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                IDLE:
                begin
                    if (s_tvalid)
                    begin
                        req_reg        <= in_req;
                        blk_off_reg    <= in_blk[SH-1:0];
                        lim_reg        <= lim;
                        last_word_reg  <= AW'((lim - LW'(1)) >> SH);
                        tail_rem_reg   <= lim[SH-1:0];
                        grant_reg      <= '0;
                        wr_en_reg      <= 1'b0;
                        chk_addr_reg   <= rd_addr;
                        issue_addr_reg <= rd_addr + AW'(1);
                        if (in_req == bba_pkg::REQ_ALLOC)
                        begin
                            if (lim == '0)
                            begin
                                status_reg <= bba_pkg::ST_FULL;
                                state_reg  <= FIN;
                            end
                            else
                            begin
                                state_reg <= SCAN;
                            end
                        end
                        else if (in_blk_ext >= lim)
                        begin
                            status_reg <= bba_pkg::ST_RANGE;
                            state_reg  <= FIN;
                        end
                        else
                        begin
                            state_reg <= SCAN;
                        end
                    end
                end

                SCAN:
                begin
                    // the word read last cycle is checked here, the next one is in flight
                    chk_addr_reg   <= issue_addr_reg;
                    issue_addr_reg <= issue_addr_reg + AW'(1);
                    wr_addr_reg    <= chk_addr_reg;
                    if (req_reg == bba_pkg::REQ_FREE)
                    begin
                        if (!word_cur[blk_off_reg])
                        begin
                            status_reg <= bba_pkg::ST_DOUBLE_FREE;
                        end
                        else
                        begin
                            wr_en_reg   <= 1'b1;
                            wr_data_reg <= word_cur & ~(W'(1) << blk_off_reg);
                            status_reg  <= bba_pkg::ST_OK;
                        end
                        state_reg <= FIN;
                    end
                    else if (found)
                    begin
                        wr_en_reg   <= 1'b1;
                        wr_data_reg <= word_cur | (W'(1) << found_idx);
                        grant_reg   <= BW'(grant_ext);
                        status_reg  <= bba_pkg::ST_OK;
                        state_reg   <= FIN;
                    end
                    else if (last_hit)
                    begin
                        status_reg <= bba_pkg::ST_FULL;
                        state_reg  <= FIN;
                    end
                end

                FIN:
                begin
                    // write-back and result go together once the output register is free
                    if (out_load)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_block_reg  <= grant_reg;
                        m_status_reg <= status_reg;
                        wr_en_reg    <= 1'b0;
                        state_reg    <= IDLE;
                    end
                end

                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    // an accepted request always leaves the idle state
    `BBA_ASSERT_NXT(a_accept_leaves_idle, s_tvalid && s_tready, state_reg != IDLE,
        "accepted request did not start")
    // every map write-back comes with a result in the output register
    `BBA_ASSERT_NXT(a_write_with_result, mem_we, m_tvalid_reg && state_reg == IDLE,
        "map written without a result")
    // a granted block lies below the effective size
    `BBA_ASSERT_IMP(a_grant_in_range,
        out_load && req_reg == bba_pkg::REQ_ALLOC && status_reg == bba_pkg::ST_OK,
        LW'(grant_reg) < lim_reg && wr_en_reg, "grant outside the file system")
    // a failed request never changes the map
    `BBA_ASSERT_IMP(a_fail_no_write, state_reg == FIN && status_reg != bba_pkg::ST_OK,
        !wr_en_reg && grant_reg == '0, "failed request would modify the map")

endmodule

// ===== test/tb_alloc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_alloc_pkg
// usage map predictor and result scoreboard for the block bitmap allocator
// ----------------------------------------------------------------------------
package tb_alloc_pkg;

    import bba_pkg::*;

    localparam int MAP_BLOCKS = 4096;

    typedef struct {
        logic [BLOCK_W-1:0] block;
        status_t            status;
    } alloc_result_t;

    class alloc_scoreboard;

        bit                 used [MAP_BLOCKS];
        logic [SIZE_W-1:0]  fs_size;
        alloc_result_t      pending_q [$];
        int                 errors;

        function new();
            foreach (used[i])
                used[i] = 1'b0;
            fs_size = 13'd4096;
            errors  = 0;
        endfunction

        function void write_size(logic [SIZE_W-1:0] value);
            fs_size = value;
        endfunction

        // sizes above the map capacity behave as the full map
        function int unsigned size_limit();
            return (fs_size > MAP_BLOCKS) ? MAP_BLOCKS : int'(fs_size);
        endfunction

        function int pending();
            return pending_q.size();
        endfunction

        // random block in use below the current size, -1 if there is none
        function int pick_used();
            int          cands [$];
            int unsigned lim;
            lim = size_limit();
            for (int n = 0; n < lim; n++)
                if (used[n])
                    cands.push_back(n);
            if (cands.size() == 0)
                return -1;
            return cands[$urandom_range(cands.size() - 1)];
        endfunction

        function void note_request(req_t req, logic [BLOCK_W-1:0] blk);
            alloc_result_t res;
            int unsigned   lim;
            bit            found;
            lim       = size_limit();
            res.block = '0;
            found     = 1'b0;
            if (req == REQ_ALLOC)
            begin
                res.status = ST_FULL;
                for (int n = 0; n < lim; n++)
                begin
                    if (!found && !used[n])
                    begin
                        used[n]    = 1'b1;
                        res.block  = n[BLOCK_W-1:0];
                        res.status = ST_OK;
                        found      = 1'b1;
                    end
                end
            end
            else if (blk >= lim)
                res.status = ST_RANGE;
            else if (!used[blk])
                res.status = ST_DOUBLE_FREE;
            else
            begin
                used[blk]  = 1'b0;
                res.status = ST_OK;
            end
            pending_q.push_back(res);
        endfunction

        task report_mismatch(string what);
            errors++;
            $display("[%0t] mismatch: %s", $time, what);
        endtask

        task check_result(logic [TDATA_W-1:0] tdata);
            alloc_result_t exp;
            if (pending_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result tdata=0x%04h", tdata));
                return;
            end
            exp = pending_q.pop_front();
            if (tdata[BLOCK_W-1:0] !== exp.block)
                report_mismatch($sformatf("alloc_block got %0d exp %0d",
                                          tdata[BLOCK_W-1:0], exp.block));
            if (tdata[BLOCK_W+STATUS_W-1:BLOCK_W] !== exp.status)
                report_mismatch($sformatf("status got %0d exp %0d",
                                          tdata[BLOCK_W+STATUS_W-1:BLOCK_W], exp.status));
        endtask

    endclass

endpackage

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for block_bitmap_allocator_unit: directed corner
// requests, then phases of random allocate and free traffic over several
// file system sizes and idling mixes, checked against a usage map predictor
// ----------------------------------------------------------------------------
module tb_top;

    import bba_pkg::*;
    import tb_alloc_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;   // far above the slowest legal run
    localparam int DRAIN_WAIT  = 140;       // longer than a full-map scan

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [TDATA_W-1:0]   s_tdata;          // [11:0] block_number, [15:12] zero
    logic                 s_tuser;          // [0] req_type
    logic                 m_tvalid;
    logic                 m_tready;
    logic [TDATA_W-1:0]   m_tdata;          // [11:0] alloc_block, [13:12] status
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [SIZE_W-1:0]    cfg_data;         // fs_size_blocks

    alloc_scoreboard      sb;
    int                   tx_idle_pct;      // sender idle chance per cycle
    int                   rx_stall_pct;     // receiver stall chance per cycle
    int                   rx_hold_cycles;   // long hold-off, counted down by the receiver
    int unsigned          cycle_count;

    block_bitmap_allocator_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // 12 ns clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run limit, fails the run if traffic ever locks up
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // monitor: every transaction is seen here at the rising edge
    // results are checked before the new request is noted, so an expectation
    // is never matched against a result of the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if (s_tvalid && s_tready)
                sb.note_request(req_t'(s_tuser), s_tdata[BLOCK_W-1:0]);
            if (cfg_valid && cfg_ready)
                sb.write_size(cfg_data);
        end
    end

    // receiver: random stalls, or a long hold-off when one is requested
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_cycles > 0)
            begin
                m_tready = 1'b0;
                rx_hold_cycles--;
            end
            else
                m_tready = ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // one request transaction; called and returns at a falling edge
    task send_request(input req_t req, input logic [BLOCK_W-1:0] blk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = req;
        s_tdata  = {{(TDATA_W-BLOCK_W){1'b0}}, blk};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // size register write, only once every result is back
    task write_fs_size(input logic [SIZE_W-1:0] value);
        s_tvalid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // mostly well-formed traffic: allocates and frees of blocks in use,
    // with a share of frees of random blocks (free, out of range, any bits)
    task random_request(input int alloc_pct);
        int          pick;
        int          used_blk;
        int unsigned lim;
        pick = $urandom_range(99);
        lim  = sb.size_limit();
        if (pick < alloc_pct)
            send_request(REQ_ALLOC, BLOCK_W'($urandom));
        else if (pick < alloc_pct + (100 - alloc_pct) * 2 / 3)
        begin
            used_blk = sb.pick_used();
            if (used_blk < 0)
                send_request(REQ_ALLOC, BLOCK_W'($urandom));
            else
                send_request(REQ_FREE, BLOCK_W'(used_blk));
        end
        else if (lim > 0 && $urandom_range(1))
            send_request(REQ_FREE, BLOCK_W'($urandom_range(lim - 1)));
        else
            send_request(REQ_FREE, BLOCK_W'($urandom));
    endtask

    // one phase of random traffic at a given size and idling mix
    task run_phase(input logic [SIZE_W-1:0] size, input int tx_pct, input int rx_pct,
                   input int alloc_pct, input int n_items, input bit with_hold);
        write_fs_size(size);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        for (int i = 0; i < n_items; i++)
        begin
            // receiver holds off long enough for the block to back up its input
            if (with_hold && i == 10)
                rx_hold_cycles = 400;
            random_request(alloc_pct);
        end
        s_tvalid = 1'b0;
    endtask

    initial
    begin
        sb             = new();
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = REQ_ALLOC;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        tx_idle_pct    = 0;
        rx_stall_pct   = 0;
        rx_hold_cycles = 0;
        cycle_count    = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: reset size, lowest blocks, double free, top block number
        send_request(REQ_ALLOC, 12'hFFF);
        send_request(REQ_ALLOC, 12'h000);
        send_request(REQ_FREE,  12'd1);
        send_request(REQ_FREE,  12'd1);
        send_request(REQ_FREE,  12'hFFF);
        send_request(REQ_FREE,  12'd0);
        send_request(REQ_ALLOC, 12'h000);
        send_request(REQ_ALLOC, 12'h000);
        send_request(REQ_ALLOC, 12'h000);
        // size zero: allocate has no room, any free is out of range
        write_fs_size(13'd0);
        send_request(REQ_ALLOC, 12'h000);
        send_request(REQ_FREE,  12'd0);
        send_request(REQ_FREE,  12'hFFF);
        // size above capacity acts as the full map
        write_fs_size(13'h1FFF);
        send_request(REQ_ALLOC, 12'h000);
        send_request(REQ_FREE,  12'hFFF);
        send_request(REQ_FREE,  12'd3);
        // shrunk map: blocks above the size stay in use but cannot be reached
        write_fs_size(13'd2);
        send_request(REQ_ALLOC, 12'h000);
        send_request(REQ_FREE,  12'd3);
        send_request(REQ_FREE,  12'd2);
        send_request(REQ_FREE,  12'd1);
        send_request(REQ_ALLOC, 12'h000);
        send_request(REQ_ALLOC, 12'h000);
        // raise the size again, block 2 becomes freeable
        write_fs_size(13'd4);
        send_request(REQ_FREE,  12'd2);
        send_request(REQ_ALLOC, 12'h000);
        send_request(REQ_ALLOC, 12'h000);
        s_tvalid = 1'b0;

        // random phases: size, sender idle, receiver stall, alloc share, items, hold
        run_phase(13'd4096, 0,  0,  45, 80, 1'b0);
        run_phase(13'd40,   65, 0,  55, 80, 1'b0);
        run_phase(13'h1FFF, 0,  65, 50, 80, 1'b1);
        run_phase(13'd1,    11, 11, 50, 40, 1'b0);
        run_phase(13'd64,   0,  0,  70, 80, 1'b0);
        run_phase(13'd20,   65, 0,  40, 50, 1'b0);
        run_phase(13'd64,   0,  65, 45, 50, 1'b0);
        run_phase(13'd0,    11, 11, 50, 20, 1'b0);
        run_phase(13'd33,   65, 65, 60, 40, 1'b0);
        // deep scans over a filling full-size map
        run_phase(13'd4096, 11, 11, 90, 100, 1'b0);

        while (sb.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
